// File: hw/rtl/sfl_pkg.sv
`default_nettype none
package sfl_pkg;

  // Run geometry
  localparam int MAX_SLOTS = 1024;
  localparam int RUN_BYTES = 65536;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int LINK_W    = SLOT_W + 1;

  // Field and register widths
  localparam int FUNC_W     = 2;
  localparam int BSIZE_W    = 17;
  localparam int OFF_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(MAX_SLOTS);

  // Offsets wrap at the run size, then keep the low field bits
  localparam logic [OFF_W-1:0] OFF_MASK =
    (RUN_BYTES >= (1 << OFF_W)) ? {OFF_W{1'b1}} : OFF_W'(RUN_BYTES - 1);

  // Register reset values
  localparam logic [BSIZE_W-1:0] BSIZE_RST  = BSIZE_W'(64);
  localparam logic [OFF_W-1:0]   FOFF_RST   = OFF_W'(64);
  localparam logic [LINK_W-1:0]  SCOUNT_RST = LINK_W'(1023);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_REBUILD = 2'd0,
    FUNC_ALLOC   = 2'd1,
    FUNC_FREE    = 2'd2,
    FUNC_DRAIN   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_BYTES   = 2'd0,
    CFG_FIRST_OFFSET = 2'd1,
    CFG_SLOT_COUNT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    func_t             func;
    logic [SLOT_W-1:0] slot;
    logic              from_owner;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic              valid;
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic              has_off;
    logic [LINK_W-1:0] in_use;
  } res_t;

  // Any head or link at or above the marker means end of stack
  function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] v);
    return (v >= EMPTY_MARK) ? EMPTY_MARK : v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/slab_free_list_allocator_unit.sv
`default_nettype none
// Slab run free-list allocator: local and remote free stacks over one link memory.
// Commands: drive in_func/in_slot/in_from_owner with start; a beat is taken at a
// clock edge where start is high and busy is low. Accepted beats wait in a
// two-entry queue, so busy rises only when that queue is full or during init.
// Results: one beat per command, shown for one cycle with out_valid high; the
// receiver cannot hold it off and the pipeline never waits on it.
// Path to out_valid: queue entry, back-end state machine (allocate adds ST_ALLOC
// for the registered link read, drain adds ST_DRAIN_CHK and ST_DRAIN_MOV per
// moved slot, rebuild one link write per slot), back-end result register, then
// the s1 and output result registers. Throughput: a free every cycle in ST_IDLE.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects block size,
// first offset or slot count; cfg_ready is always high. Write only while idle.
// Reset: registers take their defaults and the link memory is rebuilt in a
// sweep over every slot, during which busy stays high and no command is taken.
module slab_free_list_allocator_unit
  import sfl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [SLOT_W-1:0]     in_slot,
  input  wire logic                  in_from_owner,
  output logic                       out_valid,
  output logic                       out_granted,
  output logic [SLOT_W-1:0]          out_slot_out,
  output logic [OFF_W-1:0]           out_block_offset,
  output logic [LINK_W-1:0]          out_in_use,
  output logic                       out_run_empty,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BSIZE_W-1:0] slot_bytes_r;
  logic [OFF_W-1:0]   first_offset_r;
  logic [LINK_W-1:0]  slot_count_r;
  logic               boot_busy;
  logic               pop;
  q_head_t            q_head;
  res_t               res;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r   <= BSIZE_RST;
      first_offset_r <= FOFF_RST;
      slot_count_r   <= SCOUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SLOT_BYTES:   slot_bytes_r   <= cfg_data[BSIZE_W-1:0];
        CFG_FIRST_OFFSET: first_offset_r <= cfg_data[OFF_W-1:0];
        CFG_SLOT_COUNT:   slot_count_r   <= cfg_data[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  sfl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .boot_busy     (boot_busy),
    .in_func       (in_func),
    .in_slot       (in_slot),
    .in_from_owner (in_from_owner),
    .pop           (pop),
    .busy          (busy),
    .q_head        (q_head)
  );

  sfl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .slot_count (slot_count_r),
    .pop        (pop),
    .boot_busy  (boot_busy),
    .res        (res)
  );

  sfl_result u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .slot_bytes       (slot_bytes_r),
    .first_offset     (first_offset_r),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_slot_out     (out_slot_out),
    .out_block_offset (out_block_offset),
    .out_in_use       (out_in_use),
    .out_run_empty    (out_run_empty)
  );

  // The link memory rebuild after reset keeps the command port closed
  a_boot_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A granted slot is always counted in use
  a_grant_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_in_use != '0)
    else $error("grant with zero use count");

  // The use count never passes the slot capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_in_use <= LINK_W'(MAX_SLOTS))
    else $error("use count above capacity");

endmodule
`default_nettype wire

// File: hw/rtl/sfl_ram.sv
`default_nettype none
module sfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: hw/rtl/sfl_front.sv
`default_nettype none
module sfl_front
  import sfl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              boot_busy,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic              in_from_owner,
  input  wire logic              pop,
  output logic                   busy,
  output q_head_t                q_head
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              full;
  logic              push;
  item_t             new_item;

  // Hold off new beats while the queue is full or the link memory is being built
  assign full = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign busy = full || boot_busy;
  assign push = start && !busy;

  // Classify the command
  always_comb begin
    new_item.func       = func_t'(in_func);
    new_item.slot       = in_slot;
    new_item.from_owner = in_from_owner;
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: hw/rtl/sfl_back.sv
`default_nettype none
module sfl_back
  import sfl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_head_t           q_head,
  input  wire logic [LINK_W-1:0] slot_count,
  output logic                   pop,
  output logic                   boot_busy,
  output res_t                   res
);

  typedef enum logic [4:0] {
    ST_SWEEP     = 5'b00001,
    ST_IDLE      = 5'b00010,
    ST_ALLOC     = 5'b00100,
    ST_DRAIN_CHK = 5'b01000,
    ST_DRAIN_MOV = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LINK_W-1:0] local_head_r, local_head_nxt;
  logic [LINK_W-1:0] remote_head_r, remote_head_nxt;
  logic [LINK_W-1:0] use_count_r, use_count_nxt;
  logic [SLOT_W-1:0] sweep_idx_r, sweep_idx_nxt;
  logic [LINK_W-1:0] sweep_n_r, sweep_n_nxt;
  logic              sweep_emit_r, sweep_emit_nxt;
  logic              boot_r, boot_nxt;
  logic [LINK_W-1:0] walk_head_r, walk_head_nxt;
  logic [LINK_W-1:0] moves_r, moves_nxt;
  logic [SLOT_W-1:0] last_r, last_nxt;
  logic              any_r, any_nxt;
  res_t              res_r, res_nxt;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [LINK_W-1:0] wr_data;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [LINK_W-1:0] rd_data;

  logic [LINK_W-1:0] count_dn;
  logic [LINK_W-1:0] count_up;
  logic [LINK_W-1:0] sc_clamp;
  logic [LINK_W-1:0] idx_inc;

  sfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Saturating use count steps
  assign count_dn = (use_count_r != '0) ? use_count_r - 1'b1 : use_count_r;
  assign count_up = (use_count_r < EMPTY_MARK) ? use_count_r + 1'b1 : use_count_r;
  assign sc_clamp = (slot_count > EMPTY_MARK) ? EMPTY_MARK : slot_count;
  assign idx_inc  = {1'b0, sweep_idx_r} + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    local_head_nxt  = local_head_r;
    remote_head_nxt = remote_head_r;
    use_count_nxt   = use_count_r;
    sweep_idx_nxt   = sweep_idx_r;
    sweep_n_nxt     = sweep_n_r;
    sweep_emit_nxt  = sweep_emit_r;
    boot_nxt        = boot_r;
    walk_head_nxt   = walk_head_r;
    moves_nxt       = moves_r;
    last_nxt        = last_r;
    any_nxt         = any_r;
    res_nxt         = '0;
    pop             = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state_r)
      // Chain every entry to the next, end the chain at the last configured slot
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx_r;
        wr_data = (idx_inc == sweep_n_r) ? EMPTY_MARK : idx_inc;
        if (sweep_idx_r == SLOT_W'(MAX_SLOTS - 1)) begin
          local_head_nxt  = (sweep_n_r != '0) ? '0 : EMPTY_MARK;
          remote_head_nxt = EMPTY_MARK;
          use_count_nxt   = '0;
          boot_nxt        = 1'b0;
          state_nxt       = ST_IDLE;
          if (sweep_emit_r) begin
            res_nxt.valid   = 1'b1;
            res_nxt.has_off = 1'b1;
          end
        end else begin
          sweep_idx_nxt = sweep_idx_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_head.valid) begin
          pop = 1'b1;
          unique case (q_head.item.func)
            FUNC_REBUILD: begin
              sweep_idx_nxt  = '0;
              sweep_n_nxt    = sc_clamp;
              sweep_emit_nxt = 1'b1;
              state_nxt      = ST_SWEEP;
            end
            FUNC_ALLOC: begin
              if (local_head_r >= EMPTY_MARK) begin
                res_nxt.valid = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = local_head_r[SLOT_W-1:0];
                state_nxt = ST_ALLOC;
              end
            end
            FUNC_FREE: begin
              res_nxt.valid   = 1'b1;
              res_nxt.slot    = q_head.item.slot;
              res_nxt.has_off = 1'b1;
              if ({1'b0, q_head.item.slot} < EMPTY_MARK) begin
                wr_en   = 1'b1;
                wr_addr = q_head.item.slot;
                if (q_head.item.from_owner) begin
                  wr_data        = local_head_r;
                  local_head_nxt = {1'b0, q_head.item.slot};
                  use_count_nxt  = count_dn;
                end else begin
                  wr_data         = remote_head_r;
                  remote_head_nxt = {1'b0, q_head.item.slot};
                end
              end
            end
            FUNC_DRAIN: begin
              walk_head_nxt   = remote_head_r;
              remote_head_nxt = EMPTY_MARK;
              moves_nxt       = '0;
              last_nxt        = '0;
              any_nxt         = 1'b0;
              state_nxt       = ST_DRAIN_CHK;
            end
            default: ;
          endcase
        end
      end

      // Pop: the link read of the old head is back
      ST_ALLOC: begin
        local_head_nxt  = norm_link(rd_data);
        use_count_nxt   = count_up;
        res_nxt.valid   = 1'b1;
        res_nxt.granted = 1'b1;
        res_nxt.slot    = local_head_r[SLOT_W-1:0];
        res_nxt.has_off = 1'b1;
        state_nxt       = ST_IDLE;
      end

      // Stop at the end of the remote chain or after a full run of moves
      ST_DRAIN_CHK: begin
        if (walk_head_r >= EMPTY_MARK || moves_r == LINK_W'(MAX_SLOTS)) begin
          res_nxt.valid   = 1'b1;
          res_nxt.slot    = last_r;
          res_nxt.has_off = any_r;
          state_nxt       = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = walk_head_r[SLOT_W-1:0];
          state_nxt = ST_DRAIN_MOV;
        end
      end

      // Move one remote slot onto the local stack
      ST_DRAIN_MOV: begin
        wr_en          = 1'b1;
        wr_addr        = walk_head_r[SLOT_W-1:0];
        wr_data        = local_head_r;
        local_head_nxt = walk_head_r;
        use_count_nxt  = count_dn;
        last_nxt       = walk_head_r[SLOT_W-1:0];
        any_nxt        = 1'b1;
        walk_head_nxt  = norm_link(rd_data);
        moves_nxt      = moves_r + 1'b1;
        state_nxt      = ST_DRAIN_CHK;
      end

      default: state_nxt = ST_IDLE;
    endcase

    res_nxt.in_use = use_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      local_head_r  <= EMPTY_MARK;
      remote_head_r <= EMPTY_MARK;
      use_count_r   <= '0;
      sweep_idx_r   <= '0;
      sweep_n_r     <= (SCOUNT_RST > EMPTY_MARK) ? EMPTY_MARK : SCOUNT_RST;
      sweep_emit_r  <= 1'b0;
      boot_r        <= 1'b1;
      walk_head_r   <= EMPTY_MARK;
      moves_r       <= '0;
      any_r         <= 1'b0;
      res_r.valid   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      local_head_r  <= local_head_nxt;
      remote_head_r <= remote_head_nxt;
      use_count_r   <= use_count_nxt;
      sweep_idx_r   <= sweep_idx_nxt;
      sweep_n_r     <= sweep_n_nxt;
      sweep_emit_r  <= sweep_emit_nxt;
      boot_r        <= boot_nxt;
      walk_head_r   <= walk_head_nxt;
      moves_r       <= moves_nxt;
      any_r         <= any_nxt;
      res_r.valid   <= res_nxt.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    last_r          <= last_nxt;
    res_r.granted   <= res_nxt.granted;
    res_r.slot      <= res_nxt.slot;
    res_r.has_off   <= res_nxt.has_off;
    res_r.in_use    <= res_nxt.in_use;
  end

  assign boot_busy = boot_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/sfl_result.sv
`default_nettype none
module sfl_result
  import sfl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire res_t               res,
  input  wire logic [BSIZE_W-1:0] slot_bytes,
  input  wire logic [OFF_W-1:0]   first_offset,
  output logic                    out_valid,
  output logic                    out_granted,
  output logic [SLOT_W-1:0]       out_slot_out,
  output logic [OFF_W-1:0]        out_block_offset,
  output logic [LINK_W-1:0]       out_in_use,
  output logic                    out_run_empty
);

  localparam int PROD_W = SLOT_W + OFF_W;

  logic [PROD_W-1:0] prod_full;
  logic              s1_valid_r;
  logic              s1_granted_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_has_off_r;
  logic [LINK_W-1:0] s1_in_use_r;
  logic [OFF_W-1:0]  s1_prod_r;
  logic [OFF_W-1:0]  off_sum;

  logic              valid_r;
  logic              granted_r;
  logic [SLOT_W-1:0] slot_r;
  logic [OFF_W-1:0]  offset_r;
  logic [LINK_W-1:0] in_use_r;

  // Slot times block size; the block size bits above the offset field drop out
  assign prod_full = PROD_W'(res.slot) * PROD_W'(slot_bytes[OFF_W-1:0]);
  assign off_sum   = (first_offset + s1_prod_r) & OFF_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      s1_valid_r <= res.valid;
      valid_r    <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_granted_r <= res.granted;
    s1_slot_r    <= res.slot;
    s1_has_off_r <= res.has_off;
    s1_in_use_r  <= res.in_use;
    s1_prod_r    <= prod_full[OFF_W-1:0];
    granted_r    <= s1_granted_r;
    slot_r       <= s1_slot_r;
    offset_r     <= s1_has_off_r ? off_sum : '0;
    in_use_r     <= s1_in_use_r;
  end

  assign out_valid        = valid_r;
  assign out_granted      = granted_r;
  assign out_slot_out     = slot_r;
  assign out_block_offset = offset_r;
  assign out_in_use       = in_use_r;
  assign out_run_empty    = (in_use_r == '0);

endmodule
`default_nettype wire
